// File: rtl/cosine_similarity_defines.svh
// Assertion macros shared by the cosine similarity block.
`ifndef COSINE_SIMILARITY_DEFINES_SVH
`define COSINE_SIMILARITY_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define CS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cs_pkg.sv
// Shared widths, codes and control structs of the cosine similarity block.
package cs_pkg;

  localparam int ELEM_W  = 16;
  localparam int SQ_W    = 41;
  localparam int CROSS_W = 42;
  localparam int CFG_W   = 42;
  localparam int RES_W   = 16;

  // Shift-add multiplier sizing.
  localparam int MUL_A_W  = 2 * SQ_W;
  localparam int MUL_B_W  = CROSS_W;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // Quotient search.
  localparam int Q_W    = 17;
  localparam int STEP_W = 4;
  localparam int M_W    = 32;
  localparam int NUM_W  = 84;
  localparam int NUM_SH = 32;

  localparam logic [CFG_W-1:0] MIN_NORM_SQ_RST = CFG_W'(1);

  typedef enum logic [1:0] {
    MUL_AB,
    MUL_NUM,
    MUL_T
  } mul_sel_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_FLOOR,
    OUT_ZERO,
    OUT_CALC
  } out_sel_t;

  typedef struct packed {
    logic     acc;
    logic     clr;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     load_prod;
    logic     load_num;
    logic     search_init;
    logic     load_m;
    logic     cmp_step;
    logic     skip_step;
    out_sel_t out_sel;
  } cs_cmd_t;

  typedef struct packed {
    logic below_floor;
    logic any_zero;
    logic mul_done;
    logic t_over;
    logic last_step;
  } cs_status_t;

endpackage

// File: rtl/cs_in_if.sv
// Input channel: one element pair per item.
interface cs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] elem_a;
  logic signed [15:0] elem_b;
  logic               last_element;

  modport source (output valid, elem_a, elem_b, last_element, input ready);
  modport sink   (input valid, elem_a, elem_b, last_element, output ready);
endinterface

// File: rtl/cs_out_if.sv
// Result channel: one similarity value per vector pair.
interface cs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] similarity;
  logic               zero_norm;

  modport source (output valid, similarity, zero_norm, input ready);
  modport sink   (input valid, similarity, zero_norm, output ready);
endinterface

// File: rtl/cs_mul.sv
// Serial shift-add multiplier, one multiplier bit per cycle, MSB first.
module cs_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cs_pkg::MUL_A_W-1:0]  mcand,
  input  logic [cs_pkg::MUL_B_W-1:0]  mplier,
  output logic                        done,
  output logic [cs_pkg::MUL_P_W-1:0]  product
);
  import cs_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [MUL_A_W-1:0]   mcand_r;
  logic [MUL_B_W-1:0]   mplier_r;
  logic [MUL_P_W-1:0]   acc_r;
  logic [MUL_P_W-1:0]   acc_nxt;

  // Shift the partial product and add the multiplicand for a set bit.
  always_comb begin
    acc_nxt = {acc_r[MUL_P_W-2:0], 1'b0} +
              (mplier_r[MUL_B_W-1] ? {{MUL_B_W{1'b0}}, mcand_r} : '0);
  end

  // Control: busy while stepping, done pulses after the last bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands and partial product.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= mcand;
      mplier_r <= mplier;
      acc_r    <= '0;
    end else if (busy_r) begin
      mplier_r <= {mplier_r[MUL_B_W-2:0], 1'b0};
      acc_r    <= acc_nxt;
    end
  end

  assign done    = done_r;
  assign product = acc_r;
endmodule

// File: rtl/cs_datapath.sv
// Datapath: running sums, floor check, multiplier and quotient search.
module cs_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cs_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic signed [cs_pkg::ELEM_W-1:0] elem_a,
  input  logic signed [cs_pkg::ELEM_W-1:0] elem_b,
  input  cs_pkg::cs_cmd_t               cmd,
  output cs_pkg::cs_status_t            status,
  output logic signed [cs_pkg::RES_W-1:0] similarity,
  output logic                          zero_norm
);
  import cs_pkg::*;

  logic [CFG_W-1:0]          min_norm_sq_r;
  logic [SQ_W-1:0]           sum_a_r, sum_a_nxt;
  logic [SQ_W-1:0]           sum_b_r, sum_b_nxt;
  logic signed [CROSS_W-1:0] sum_c_r, sum_c_nxt;
  logic signed [2*ELEM_W-1:0] pa, pb, pc;
  logic [SQ_W:0]             sa_sum, sb_sum;
  logic signed [CROSS_W:0]   sc_sum;
  logic [CROSS_W-1:0]        mag;
  logic [MUL_A_W-1:0]        mcand;
  logic [MUL_B_W-1:0]        mplier;
  logic                      mul_done;
  logic [MUL_P_W-1:0]        product;
  logic [MUL_A_W-1:0]        prod_r;
  logic [NUM_W-1:0]          num_r;
  logic [Q_W-1:0]            q_r, t_r, t_val;
  logic [STEP_W-1:0]         k_r;
  logic [ELEM_W-1:0]         d_val;
  logic [M_W-1:0]            m_r;
  logic                      fits;
  logic signed [RES_W-1:0]   similarity_r;
  logic                      zero_norm_r;

  // Element products and saturating accumulation.
  always_comb begin
    pa     = elem_a * elem_a;
    pb     = elem_b * elem_b;
    pc     = elem_a * elem_b;
    sa_sum = {1'b0, sum_a_r} + (SQ_W + 1)'(unsigned'(pa));
    sb_sum = {1'b0, sum_b_r} + (SQ_W + 1)'(unsigned'(pb));
    sc_sum = (CROSS_W + 1)'(sum_c_r) + (CROSS_W + 1)'(pc);
    sum_a_nxt = sa_sum[SQ_W] ? {SQ_W{1'b1}} : sa_sum[SQ_W-1:0];
    sum_b_nxt = sb_sum[SQ_W] ? {SQ_W{1'b1}} : sb_sum[SQ_W-1:0];
    if (sc_sum[CROSS_W] != sc_sum[CROSS_W-1]) begin
      sum_c_nxt = sc_sum[CROSS_W] ? {1'b1, {(CROSS_W-1){1'b0}}}
                                  : {1'b0, {(CROSS_W-1){1'b1}}};
    end else begin
      sum_c_nxt = sc_sum[CROSS_W-1:0];
    end
  end

  // Magnitude of the dot product and multiplier operand selection.
  always_comb begin
    mag = sum_c_r[CROSS_W-1] ? (~sum_c_r + 1'b1) : sum_c_r;
    case (cmd.mul_sel)
      MUL_AB: begin
        mcand  = MUL_A_W'(sum_a_r);
        mplier = MUL_B_W'(sum_b_r);
      end
      MUL_NUM: begin
        mcand  = MUL_A_W'(mag);
        mplier = mag;
      end
      MUL_T: begin
        mcand  = prod_r;
        mplier = MUL_B_W'(m_r);
      end
      default: begin
        mcand  = '0;
        mplier = '0;
      end
    endcase
  end

  cs_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .mcand   (mcand),
    .mplier  (mplier),
    .done    (mul_done),
    .product (product)
  );

  // Candidate quotient, its odd double, and the squared-bound test.
  always_comb begin
    t_val = q_r + (Q_W'(1) << k_r);
    d_val = {t_val[ELEM_W-2:0], 1'b0} - 1'b1;
    fits  = product <= MUL_P_W'({num_r, {NUM_SH{1'b0}}});
  end

  // Status to the controller.
  always_comb begin
    status.below_floor = ({1'b0, sum_a_r} < min_norm_sq_r) ||
                         ({1'b0, sum_b_r} < min_norm_sq_r);
    status.any_zero    = (sum_a_r == '0) || (sum_b_r == '0);
    status.mul_done    = mul_done;
    status.t_over      = t_val > Q_W'(32768);
    status.last_step   = k_r == '0;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_norm_sq_r <= MIN_NORM_SQ_RST;
    end else if (cfg_we) begin
      min_norm_sq_r <= cfg_wdata;
    end
  end

  // Running sums, cleared after every result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_a_r <= '0;
      sum_b_r <= '0;
      sum_c_r <= '0;
    end else if (cmd.clr) begin
      sum_a_r <= '0;
      sum_b_r <= '0;
      sum_c_r <= '0;
    end else if (cmd.acc) begin
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      sum_c_r <= sum_c_nxt;
    end
  end

  // Products and quotient search registers.
  always_ff @(posedge clk) begin
    if (cmd.load_prod) begin
      prod_r <= product[MUL_A_W-1:0];
    end
    if (cmd.load_num) begin
      num_r <= product[NUM_W-1:0];
    end
    if (cmd.search_init) begin
      q_r <= '0;
      k_r <= STEP_W'(Q_W - 2);
    end else if (cmd.cmp_step) begin
      if (fits) begin
        q_r <= t_r;
      end
      k_r <= k_r - 1'b1;
    end else if (cmd.skip_step) begin
      k_r <= k_r - 1'b1;
    end
    if (cmd.load_m) begin
      t_r <= t_val;
      m_r <= M_W'(d_val) * M_W'(d_val);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    case (cmd.out_sel)
      OUT_FLOOR: begin
        similarity_r <= '0;
        zero_norm_r  <= 1'b1;
      end
      OUT_ZERO: begin
        similarity_r <= '0;
        zero_norm_r  <= 1'b0;
      end
      OUT_CALC: begin
        if (sum_c_r[CROSS_W-1]) begin
          similarity_r <= RES_W'(~q_r + 1'b1);
        end else if (q_r > Q_W'(32767)) begin
          similarity_r <= RES_W'(32767);
        end else begin
          similarity_r <= q_r[RES_W-1:0];
        end
        zero_norm_r <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign similarity = similarity_r;
  assign zero_norm  = zero_norm_r;
endmodule

// File: rtl/cs_ctrl.sv
// Controller: accumulation, norm checks, multiplies and quotient search.
module cs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  input  logic               out_ready,
  input  cs_pkg::cs_status_t status,
  output logic               in_ready,
  output logic               out_valid,
  output cs_pkg::cs_cmd_t    cmd
);
  import cs_pkg::*;

  typedef enum logic [3:0] {
    S_ACC,
    S_CHECK,
    S_MUL_AB,
    S_MUL_NUM,
    S_SQ,
    S_TSTART,
    S_MUL_T,
    S_CMP,
    S_FIN,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_AB;
    cmd.out_sel = OUT_NONE;
    case (state_r)
      S_ACC: begin
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (in_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (status.below_floor) begin
          cmd.out_sel = OUT_FLOOR;
          cmd.clr     = 1'b1;
          state_nxt   = S_OUT;
        end else if (status.any_zero) begin
          cmd.out_sel = OUT_ZERO;
          cmd.clr     = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_AB;
          state_nxt     = S_MUL_AB;
        end
      end
      S_MUL_AB: begin
        if (status.mul_done) begin
          cmd.load_prod = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_NUM;
          state_nxt     = S_MUL_NUM;
        end
      end
      S_MUL_NUM: begin
        if (status.mul_done) begin
          cmd.load_num    = 1'b1;
          cmd.search_init = 1'b1;
          state_nxt       = S_SQ;
        end
      end
      S_SQ: begin
        if (status.t_over) begin
          cmd.skip_step = 1'b1;
          state_nxt     = status.last_step ? S_FIN : S_SQ;
        end else begin
          cmd.load_m = 1'b1;
          state_nxt  = S_TSTART;
        end
      end
      S_TSTART: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_T;
        state_nxt     = S_MUL_T;
      end
      S_MUL_T: begin
        cmd.mul_sel = MUL_T;
        if (status.mul_done) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        state_nxt    = status.last_step ? S_FIN : S_SQ;
      end
      S_FIN: begin
        cmd.out_sel = OUT_CALC;
        cmd.clr     = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= state_nxt == S_ACC;
      out_valid_r <= state_nxt == S_OUT;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;
endmodule

// File: rtl/cosine_similarity.sv
// Cosine similarity of two streamed Q4.12 vectors. Element pairs are taken one
// per cycle and folded into three saturating sums. After the item marked last
// the block stops taking items, checks both sums of squares against
// min_norm_sq and for zero, and otherwise finds the Q1.15 quotient, rounded to
// nearest, by a 16-step binary search that compares squares exactly. All wide
// products come from one shift-add multiplier; it runs twice to set up and once
// for each search step whose candidate does not exceed one. The next vector is
// taken once the result has been delivered.
module cosine_similarity (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [cs_pkg::CFG_W-1:0] cfg_wdata,
  cs_in_if.sink                    in_item,
  cs_out_if.source                 out_item
);
  import cs_pkg::*;

  `include "cosine_similarity_defines.svh"

  cs_cmd_t    cmd;
  cs_status_t status;

  cs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_last   (in_item.last_element),
    .out_ready (out_item.ready),
    .status    (status),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .cmd       (cmd)
  );

  cs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .elem_a     (in_item.elem_a),
    .elem_b     (in_item.elem_b),
    .cmd        (cmd),
    .status     (status),
    .similarity (out_item.similarity),
    .zero_norm  (out_item.zero_norm)
  );

  // A pending result and a new item never meet.
  `CS_ASSERT_IMPL(a_no_overlap, out_item.valid, !in_item.ready, "item taken with result pending")
  // The last pair of a vector closes the input until the result is out.
  `CS_ASSERT_NEXT(a_last_closes, in_item.valid && in_item.ready && in_item.last_element, !in_item.ready, "input open after last item")
  // Delivering a result reopens the input.
  `CS_ASSERT_NEXT(a_reopen, out_item.valid && out_item.ready, in_item.ready && !out_item.valid, "input not reopened after result")
endmodule

// File: tb/sv/cosine_similarity_checker.sv
// Checker for the cosine similarity block: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module cosine_similarity_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [cs_pkg::CFG_W-1:0] cfg_wdata,
  cs_in_if                         in_mon,
  cs_out_if                        out_mon,
  output int                       errors,
  output int                       pending
);
  import cs_pkg::*;

  localparam longint SQ_LIMIT    = (longint'(1) << SQ_W) - 1;
  localparam longint CROSS_TOP   = (longint'(1) << (CROSS_W - 1)) - 1;
  localparam longint CROSS_FLOOR = -(longint'(1) << (CROSS_W - 1));

  typedef struct {
    logic signed [RES_W-1:0] similarity;
    logic                    zero_norm;
  } cos_result_t;

  // Running sums and the norm floor, as the block should hold them.
  longint            acc_sq_a;
  longint            acc_sq_b;
  longint            acc_dot;
  logic [CFG_W-1:0]  norm_floor;
  cos_result_t       cos_pending[$];

  assign pending = cos_pending.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Rounded Q1.15 quotient magnitude, found by comparing squares exactly.
  function automatic int unsigned cos_magnitude(input longint sq_a, input longint sq_b,
                                                input longint dot);
    logic [127:0] num_sq;
    logic [127:0] prod;
    logic [127:0] m;
    logic [127:0] mag;
    int unsigned  q;
    int unsigned  t;
    mag = (dot < 0) ? 128'(-dot) : 128'(dot);
    num_sq = (mag << 16) * (mag << 16);
    prod = 128'(sq_a) * 128'(sq_b);
    q = 0;
    for (int unsigned step = 32768; step > 0; step >>= 1) begin
      t = q + step;
      m = 128'(2 * t - 1) * 128'(2 * t - 1);
      if (t <= 32768 && prod * m <= num_sq) q = t;
    end
    return q;
  endfunction

  // Fold one accepted pair into the sums; on the last pair queue the result.
  task automatic fold_pair(input logic signed [ELEM_W-1:0] a,
                           input logic signed [ELEM_W-1:0] b, input logic last);
    cos_result_t  r;
    int unsigned  q;
    acc_sq_a = (acc_sq_a + longint'(a) * a > SQ_LIMIT) ? SQ_LIMIT : acc_sq_a + longint'(a) * a;
    acc_sq_b = (acc_sq_b + longint'(b) * b > SQ_LIMIT) ? SQ_LIMIT : acc_sq_b + longint'(b) * b;
    acc_dot = acc_dot + longint'(a) * b;
    if (acc_dot > CROSS_TOP) acc_dot = CROSS_TOP;
    if (acc_dot < CROSS_FLOOR) acc_dot = CROSS_FLOOR;
    if (!last) return;
    r.similarity = '0;
    r.zero_norm = 1'b0;
    if (64'(acc_sq_a) < 64'(norm_floor) || 64'(acc_sq_b) < 64'(norm_floor)) begin
      r.zero_norm = 1'b1;
    end else if (acc_sq_a != 0 && acc_sq_b != 0) begin
      q = cos_magnitude(acc_sq_a, acc_sq_b, acc_dot);
      if (acc_dot >= 0) r.similarity = (q > 32767) ? 16'sd32767 : RES_W'(q);
      else r.similarity = RES_W'(-int'(q));
    end
    cos_pending = {cos_pending, r};
    acc_sq_a = 0;
    acc_sq_b = 0;
    acc_dot = 0;
  endtask

  // Sample both channels and the register port at every rising edge.
  always @(posedge clk) begin
    cos_result_t want;
    if (!rst_n) begin
      acc_sq_a = 0;
      acc_sq_b = 0;
      acc_dot = 0;
      norm_floor = MIN_NORM_SQ_RST;
      cos_pending.delete();
      errors = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (cos_pending.size() == 0) begin
          report("unexpected result item, similarity", out_mon.similarity, 0);
        end else begin
          want = cos_pending.pop_front();
          if (out_mon.similarity !== want.similarity)
            report("similarity", out_mon.similarity, want.similarity);
          if (out_mon.zero_norm !== want.zero_norm)
            report("zero_norm", out_mon.zero_norm, want.zero_norm);
        end
      end
      if (in_mon.valid && in_mon.ready)
        fold_pair(in_mon.elem_a, in_mon.elem_b, in_mon.last_element);
      if (cfg_we) norm_floor = cfg_wdata;
    end
  end
endmodule

// File: tb/sv/cosine_similarity_tb.sv
// Top of the cosine similarity testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module cosine_similarity_tb;
  import cs_pkg::*;

  localparam int LIMIT_CYCLES = 8000000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               errors;
  int               pending;
  int               hold_left;
  bit               calm;
  int               items_sent;
  int               vectors_sent;

  cs_in_if  in_item();
  cs_out_if out_item();

  cosine_similarity dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_item  (in_item),
    .out_item (out_item)
  );

  cosine_similarity_checker chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_mon   (in_item),
    .out_mon  (out_item),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle limit guards against a hung block.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", LIMIT_CYCLES, pending);
    $display("cosine_similarity_tb: errors");
    $finish;
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    int burst;
    out_item.ready = 1'b0;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_item.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_item.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 18) - 1;
        out_item.ready <= 1'b0;
      end else begin
        out_item.ready <= 1'b1;
      end
    end
  end

  // Offer one pair and hold it until it is accepted.
  task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic last);
    @(negedge clk);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_item.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_item.valid <= 1'b1;
    in_item.elem_a <= a;
    in_item.elem_b <= b;
    in_item.last_element <= last;
    do @(posedge clk); while (!in_item.ready);
    items_sent++;
    if (last) vectors_sent++;
  endtask

  // Let every expected result arrive, then give the block a few spare cycles.
  task automatic drain;
    @(negedge clk);
    in_item.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_floor(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_elem;
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3, 4, 5: return 16'($urandom_range(0, 400)) - 16'sd200;
      default: return 16'($urandom);
    endcase
  endfunction

  // One vector of random pairs, with the second element often tied to the first.
  task automatic send_random_vector(output int len);
    logic signed [15:0] a;
    logic signed [15:0] b;
    int                 tie;
    int                 sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) len = $urandom_range(1, 6);
    else if (sel < 95) len = $urandom_range(7, 40);
    else len = $urandom_range(41, 200);
    tie = $urandom_range(0, 7);
    for (int i = 0; i < len; i++) begin
      a = pick_elem();
      if (tie == 0) b = a;
      else if (tie == 1) b = -a;
      else b = pick_elem();
      send_pair(a, b, i == len - 1);
    end
  endtask

  initial begin
    int len;
    int budget;
    logic [CFG_W-1:0] floor_value;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_item.valid = 1'b0;
    in_item.elem_a = '0;
    in_item.elem_b = '0;
    in_item.last_element = 1'b0;
    hold_left = 0;
    calm = 1'b0;
    items_sent = 0;
    vectors_sent = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed pairs under the reset floor: extremes, all-zero and orthogonal vectors.
    send_pair(16'sd32767, 16'sd32767, 1'b1);
    send_pair(-16'sd32768, -16'sd32768, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    send_pair(16'sd32767, -16'sd32768, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd0, 16'sd5, 1'b1);
    send_pair(16'sd1, 16'sd0, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd1, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd1, 1'b1);
    send_pair(16'sd3, 16'sd4, 1'b0);
    send_pair(-16'sd4, 16'sd3, 1'b1);
    send_pair(16'sd1, 16'sd3, 1'b0);
    send_pair(16'sd2, -16'sd1, 1'b1);
    drain();

    // A zero floor lets an all-zero vector through without the flag.
    write_floor('0);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd0, -16'sd7, 1'b1);
    send_pair(16'sd9, 16'sd0, 1'b1);
    drain();

    // The highest floor flags every vector.
    write_floor({CFG_W{1'b1}});
    send_pair(-16'sd32768, -16'sd32768, 1'b1);
    send_pair(16'sd32767, 16'sd100, 1'b1);
    drain();

    // Random phases, each under its own floor; the last one without idling.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: floor_value = CFG_W'(1);
        1: floor_value = CFG_W'(1) << 24;
        2: floor_value = CFG_W'($urandom_range(0, 1 << 20));
        3: floor_value = '0;
        default: floor_value = CFG_W'(1) << $urandom_range(20, 34);
      endcase
      write_floor(floor_value);
      calm = (phase == 4);
      if (phase == 1) hold_left = 3000;
      budget = 390;
      while (budget > 0) begin
        send_random_vector(len);
        budget -= len;
      end
      drain();
    end

    repeat (50) @(negedge clk);
    $display("Sent %0d element pairs in %0d vectors under several norm floors,", items_sent,
             vectors_sent);
    $display("including extreme elements, zero vectors and a long receiver hold-off.");
    if (errors == 0) begin
      $display("cosine_similarity_tb: clean");
    end else begin
      $display("cosine_similarity_tb: errors");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/cs_pkg.sv
rtl/cs_in_if.sv
rtl/cs_out_if.sv
rtl/cs_mul.sv
rtl/cs_datapath.sv
rtl/cs_ctrl.sv
rtl/cosine_similarity.sv
tb/sv/cosine_similarity_checker.sv
tb/sv/cosine_similarity_tb.sv
